FILE: src/integer_pixel_upscaler_core_macros.svh
// Assertion helpers shared by the checker files.
`ifndef INTEGER_PIXEL_UPSCALER_CORE_MACROS_SVH
`define INTEGER_PIXEL_UPSCALER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IPU_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipu assertion failed");

// Next-cycle implication, disabled during reset.
`define IPU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipu assertion failed");

`endif

FILE: src/ipu_pkg.sv
package ipu_pkg;

   localparam int PIXEL_W     = 24;
   localparam int PAD_W       = 2;
   localparam int SCALE_REG_W = 7;
   localparam int WIDTH_REG_W = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH = 1'b1;

   // item opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // control part of one result
   typedef struct packed {
      logic             out_valid;
      logic [PAD_W-1:0] pad_bytes;
      logic             row_end;
      logic             refused;
   } rsp_ctl_type;

endpackage

FILE: src/integer_pixel_upscaler_core.sv
// Result: a request's result appears on the rsp_ channel in the cycle after it is accepted.
// Throughput: one transaction per cycle unless rsp_stall holds a result; every item is counter
// updates plus at most one single-port line memory access; the registered read data is rsp_out_pixel.
// Reset: synchronous, active high; clears counters, row state and output valid, and sets
// scale and src_width to 1. Line memory contents are not cleared.
module integer_pixel_upscaler_core #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [ipu_pkg::PIXEL_W-1:0]   req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_out_valid,
   output logic [ipu_pkg::PIXEL_W-1:0]   rsp_out_pixel,
   output logic [ipu_pkg::PAD_W-1:0]     rsp_pad_bytes,
   output logic                          rsp_row_end,
   output logic                          rsp_refused,
   input  logic                          csr_wr_en,
   input  logic [ipu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ipu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ipu_pkg::*;

   // counters keep at least two bits so the padding term can use bits [1:0]
   localparam int WW = ($clog2(MAX_WIDTH + 1) < 2) ? 2 : $clog2(MAX_WIDTH + 1);
   localparam int SW = ($clog2(MAX_SCALE + 1) < 2) ? 2 : $clog2(MAX_SCALE + 1);
   localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [SCALE_REG_W-1:0] scale_ff, scale_in;
   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic [WW-1:0]          fill_ff, fill_in;
   logic [WW-1:0]          ridx_ff, ridx_in;
   logic [SW-1:0]          across_ff, across_in;
   logic [SW-1:0]          down_ff, down_in;
   logic                   ready_ff, ready_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_ctl_type            rsp_ff, rsp_in;
   logic [PIXEL_W-1:0]     pix_rd_ff;

   logic [PIXEL_W-1:0]     line_mem [MAX_WIDTH];

   logic                   advance;
   logic                   accept;
   logic                   mem_wr;
   logic                   mem_rd;
   logic [WW-1:0]          w_eff;
   logic [SW-1:0]          s_eff;
   logic [WW:0]            fill_inc;
   logic [WW:0]            ridx_inc;
   logic [SW:0]            across_inc;
   logic [SW:0]            down_inc;
   logic [3:0]             pad_prod;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (scale_ff == '0) begin
         s_eff = SW'(1);
      end else if (32'(scale_ff) > 32'(MAX_SCALE)) begin
         s_eff = SW'(MAX_SCALE);
      end else begin
         s_eff = SW'(scale_ff);
      end
   end

   assign fill_inc   = {1'b0, fill_ff} + (WW + 1)'(1);
   assign ridx_inc   = {1'b0, ridx_ff} + (WW + 1)'(1);
   assign across_inc = {1'b0, across_ff} + (SW + 1)'(1);
   assign down_inc   = {1'b0, down_ff} + (SW + 1)'(1);
   // (w*s*3) padded to a multiple of 4 reduces to (w*s) mod 4
   assign pad_prod   = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};

   always_comb begin
      scale_in = scale_ff;
      width_in = width_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCALE:     scale_in = csr_wdata[SCALE_REG_W-1:0];
            CSR_SRC_WIDTH: width_in = csr_wdata[WIDTH_REG_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      ridx_in      = ridx_ff;
      across_in    = across_ff;
      down_in      = down_ff;
      ready_in     = ready_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = advance ? req_valid : rsp_valid_ff;
      if (accept) begin
         rsp_in = '0;
         if (req_op == OP_LOAD) begin
            if (ready_ff) begin
               rsp_in.refused = 1'b1;
            end else begin
               mem_wr = 1'b1;
               if (fill_inc >= {1'b0, w_eff}) begin
                  fill_in   = '0;
                  ready_in  = 1'b1;
                  ridx_in   = '0;
                  across_in = '0;
                  down_in   = '0;
               end else begin
                  fill_in = fill_inc[WW-1:0];
               end
            end
         end else if (ready_ff) begin
            mem_rd           = 1'b1;
            rsp_in.out_valid = 1'b1;
            if (across_inc >= {1'b0, s_eff}) begin
               across_in = '0;
               if (ridx_inc >= {1'b0, w_eff}) begin
                  ridx_in          = '0;
                  rsp_in.row_end   = 1'b1;
                  rsp_in.pad_bytes = pad_prod[PAD_W-1:0];
                  if (down_inc >= {1'b0, s_eff}) begin
                     down_in  = '0;
                     ready_in = 1'b0;
                  end else begin
                     down_in = down_inc[SW-1:0];
                  end
               end else begin
                  ridx_in = ridx_inc[WW-1:0];
               end
            end else begin
               across_in = across_inc[SW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_REG_W'(1);
         width_ff     <= WIDTH_REG_W'(1);
         fill_ff      <= '0;
         ridx_ff      <= '0;
         across_ff    <= '0;
         down_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         fill_ff      <= fill_in;
         ridx_ff      <= ridx_in;
         across_ff    <= across_in;
         down_ff      <= down_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // loads and ticks never share a cycle, and a write is visible to the next read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[fill_ff[IW-1:0]] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         pix_rd_ff <= line_mem[ridx_ff[IW-1:0]];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = rsp_ff.out_valid;
   assign rsp_out_pixel = rsp_ff.out_valid ? pix_rd_ff : '0;
   assign rsp_pad_bytes = rsp_ff.pad_bytes;
   assign rsp_row_end   = rsp_ff.row_end;
   assign rsp_refused   = rsp_ff.refused;

endmodule

FILE: src/ipu_checker.sv
`include "integer_pixel_upscaler_core_macros.svh"

module ipu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_op,
   input logic [ipu_pkg::PIXEL_W-1:0]    req_pixel,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_out_valid,
   input logic [ipu_pkg::PIXEL_W-1:0]    rsp_out_pixel,
   input logic [ipu_pkg::PAD_W-1:0]      rsp_pad_bytes,
   input logic                           rsp_row_end,
   input logic                           rsp_refused,
   input logic                           csr_wr_en,
   input logic [ipu_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [ipu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ipu_pkg::*;

   logic rsp_held;
   logic rsp_empty;
   logic [PIXEL_W-1:0] rsp_pixel_sum;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_empty     = !rsp_out_valid && rsp_pad_bytes == '0 && !rsp_row_end;
   assign rsp_pixel_sum = rsp_out_pixel;

   // a stalled transaction keeps its valid, pixel, out_valid, row_end and refused fields
   `IPU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_pixel_sum) && $stable(rsp_out_valid) && $stable(rsp_row_end) && $stable(rsp_refused))
   // results without a pixel carry no pixel, padding or row end
   `IPU_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && !rsp_out_valid, rsp_empty && rsp_out_pixel == '0)
   // padding is reported only on the last pixel of a row
   `IPU_ASSERT_IMPLY(a_pad_at_end, clock, reset, rsp_valid && rsp_pad_bytes != '0, rsp_row_end && rsp_out_valid)
   // a refused load never carries a pixel
   `IPU_ASSERT_IMPLY(a_refused_clean, clock, reset, rsp_valid && rsp_refused, rsp_empty)
   // with the output free, the input is never stalled
   `IPU_ASSERT_IMPLY(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall)

   logic unused_in;
   assign unused_in = ^{req_valid, req_op, req_pixel, csr_wr_en, csr_index, csr_wdata};

endmodule

bind integer_pixel_upscaler_core ipu_checker u_ipu_checker (.*);
